[rtl/text_cursor_key_editor_macros.svh]
// ----------------------------------------------------------------------------
// text cursor key editor assertion macros
// concurrent assertion helpers clocked on i_clk, with and without reset gating
// ----------------------------------------------------------------------------
`ifndef TEXT_CURSOR_KEY_EDITOR_MACROS_SVH
`define TEXT_CURSOR_KEY_EDITOR_MACROS_SVH

`ifndef SYNTHESIS

// property checked only while out of reset
`define TCKE_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("tcke assertion failed");

// property checked at every edge, reset included
`define TCKE_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) (prop)) \
        else $error("tcke assertion failed");

`else

`define TCKE_ASSERT(lbl, prop)
`define TCKE_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

[rtl/tcke_pkg.sv]
// ----------------------------------------------------------------------------
// tcke_pkg
// window geometry, key codes and shared types of the text cursor key editor
// ----------------------------------------------------------------------------
package tcke_pkg;

    // window geometry
    localparam int ROWS       = 16;
    localparam int COLS       = 63;
    localparam int TAB_SPACES = 4;
    localparam int MAX_RES    = 4;
    localparam int TAB_N      = (TAB_SPACES < MAX_RES) ? TAB_SPACES : MAX_RES;
    localparam int TAB_CNT_W  = $clog2(MAX_RES);

    // payload widths
    localparam int KEY_W  = 8;
    localparam int ROW_W  = 4;
    localparam int COL_W  = 6;
    localparam int CHAR_W = 7;

    localparam logic [ROW_W-1:0]     ROW_LAST = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]     COL_LAST = COL_W'(COLS - 1);
    localparam logic [TAB_CNT_W-1:0] TAB_LAST = TAB_CNT_W'(TAB_N - 1);

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // key codes
    localparam logic [KEY_W-1:0] KEY_LEFT     = 8'd1;
    localparam logic [KEY_W-1:0] KEY_BOTTOM   = 8'd2;
    localparam logic [KEY_W-1:0] KEY_END      = 8'd5;
    localparam logic [KEY_W-1:0] KEY_TAB      = 8'd9;
    localparam logic [KEY_W-1:0] KEY_ENTER    = 8'd13;
    localparam logic [KEY_W-1:0] KEY_HOME     = 8'd17;
    localparam logic [KEY_W-1:0] KEY_BKSP     = 8'd18;
    localparam logic [KEY_W-1:0] KEY_RIGHT    = 8'd19;
    localparam logic [KEY_W-1:0] KEY_TOP      = 8'd20;
    localparam logic [KEY_W-1:0] KEY_UP       = 8'd23;
    localparam logic [KEY_W-1:0] KEY_DOWN     = 8'd26;
    localparam logic [KEY_W-1:0] KEY_PRINT_LO = 8'd32;
    localparam logic [KEY_W-1:0] KEY_PRINT_HI = 8'd127;

    localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'd32;

    typedef enum logic [3:0] {
        OP_UP,
        OP_DOWN,
        OP_LEFT,
        OP_RIGHT,
        OP_HOME,
        OP_END,
        OP_TOP,
        OP_BOTTOM,
        OP_ENTER,
        OP_BKSP,
        OP_TAB,
        OP_CHAR
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [CHAR_W-1:0] ch;
    } t_cmd;

    typedef struct packed {
        logic              write_valid;
        logic [ROW_W-1:0]  write_row;
        logic [COL_W-1:0]  write_col;
        logic [CHAR_W-1:0] write_char;
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_col;
        logic              last_result;
    } t_res;

endpackage

[rtl/tcke_if.sv]
// ----------------------------------------------------------------------------
// tcke_if
// valid/ready channels for key codes in and cell write results out
// ----------------------------------------------------------------------------
interface tcke_key_if import tcke_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] key_code;

    modport source (output valid, output key_code, input ready);
    modport sink   (input valid, input key_code, output ready);
endinterface

interface tcke_res_if import tcke_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              write_valid;
    logic [ROW_W-1:0]  write_row;
    logic [COL_W-1:0]  write_col;
    logic [CHAR_W-1:0] write_char;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic              last_result;

    modport source (
        output valid, output write_valid, output write_row, output write_col,
        output write_char, output cursor_row, output cursor_col,
        output last_result, input ready
    );
    modport sink (
        input valid, input write_valid, input write_row, input write_col,
        input write_char, input cursor_row, input cursor_col,
        input last_result, output ready
    );
endinterface

[rtl/tcke_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// tcke_cmd_fifo
// short flop queue of decoded commands between front and back
// ----------------------------------------------------------------------------
module tcke_cmd_fifo import tcke_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_push_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

[rtl/tcke_front.sv]
// ----------------------------------------------------------------------------
// tcke_front
// accepts key codes and decodes them into editor commands, dropping dead keys
// ----------------------------------------------------------------------------
module tcke_front import tcke_pkg::*; (
    tcke_key_if.sink i_key,
    input  logic     i_queue_full,
    output logic     o_push,
    output t_cmd     o_push_cmd
);

    logic is_cmd;

    assign i_key.ready = !i_queue_full;

    always_comb begin
        is_cmd        = 1'b1;
        o_push_cmd.ch = i_key.key_code[CHAR_W-1:0];
        o_push_cmd.op = OP_CHAR;
        case (i_key.key_code)
            KEY_UP:     o_push_cmd.op = OP_UP;
            KEY_DOWN:   o_push_cmd.op = OP_DOWN;
            KEY_LEFT:   o_push_cmd.op = OP_LEFT;
            KEY_RIGHT:  o_push_cmd.op = OP_RIGHT;
            KEY_HOME:   o_push_cmd.op = OP_HOME;
            KEY_END:    o_push_cmd.op = OP_END;
            KEY_TOP:    o_push_cmd.op = OP_TOP;
            KEY_BOTTOM: o_push_cmd.op = OP_BOTTOM;
            KEY_ENTER:  o_push_cmd.op = OP_ENTER;
            KEY_BKSP:   o_push_cmd.op = OP_BKSP;
            KEY_TAB:    o_push_cmd.op = OP_TAB;
            default: begin
                // printable range writes a cell, everything else is dropped
                is_cmd = i_key.key_code inside {[KEY_PRINT_LO:KEY_PRINT_HI]};
            end
        endcase
    end

    assign o_push = i_key.valid && i_key.ready && is_cmd;

endmodule

[rtl/tcke_back.sv]
// ----------------------------------------------------------------------------
// tcke_back
// executes queued commands on the cursor and registers one result per cycle unless the output stalls
// ----------------------------------------------------------------------------
`include "text_cursor_key_editor_macros.svh"

module tcke_back import tcke_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_valid,
    input  t_cmd        i_cmd,
    output logic        o_cmd_pop,
    tcke_res_if.source  o_res
);

    logic [ROW_W-1:0]     r_row, n_row;
    logic [COL_W-1:0]     r_col, n_col;
    logic [TAB_CNT_W-1:0] r_tab_cnt, n_tab_cnt;
    logic                 r_out_valid, n_out_valid;
    t_res                 r_out, n_res;

    logic                 fire;
    logic                 tab_done;
    logic [ROW_W-1:0]     adv_row;
    logic [COL_W-1:0]     adv_col;
    logic [COL_W-1:0]     left_col;

    assign fire     = i_cmd_valid && (!r_out_valid || o_res.ready);
    assign tab_done = (r_tab_cnt == TAB_LAST);

    // advance after a cell write: next column, wrap to next row, hold at last cell
    always_comb begin
        adv_row = r_row;
        adv_col = r_col;
        if (r_col < COL_LAST) begin
            adv_col = r_col + 1'b1;
        end else if (r_row < ROW_LAST) begin
            adv_col = '0;
            adv_row = r_row + 1'b1;
        end
    end

    assign left_col = (r_col != '0) ? r_col - 1'b1 : r_col;

    always_comb begin
        n_row             = r_row;
        n_col             = r_col;
        n_res.write_valid = 1'b0;
        n_res.write_row   = '0;
        n_res.write_col   = '0;
        n_res.write_char  = '0;
        n_res.last_result = 1'b1;
        case (i_cmd.op)
            OP_UP:     n_row = (r_row != '0) ? r_row - 1'b1 : r_row;
            OP_DOWN:   n_row = (r_row < ROW_LAST) ? r_row + 1'b1 : r_row;
            OP_LEFT:   n_col = left_col;
            OP_RIGHT:  n_col = (r_col < COL_LAST) ? r_col + 1'b1 : r_col;
            OP_HOME:   n_col = '0;
            OP_END:    n_col = COL_LAST;
            OP_TOP:    n_row = '0;
            OP_BOTTOM: n_row = ROW_LAST;
            OP_ENTER: begin
                n_col = '0;
                n_row = (r_row < ROW_LAST) ? r_row + 1'b1 : r_row;
            end
            OP_BKSP: begin
                // left, write, advance, left collapses to one step left
                n_col             = left_col;
                n_res.write_valid = 1'b1;
                n_res.write_row   = r_row;
                n_res.write_col   = left_col;
                n_res.write_char  = CHAR_SPACE;
            end
            OP_TAB: begin
                n_row             = adv_row;
                n_col             = adv_col;
                n_res.write_valid = 1'b1;
                n_res.write_row   = r_row;
                n_res.write_col   = r_col;
                n_res.write_char  = CHAR_SPACE;
                n_res.last_result = tab_done;
            end
            OP_CHAR: begin
                n_row             = adv_row;
                n_col             = adv_col;
                n_res.write_valid = 1'b1;
                n_res.write_row   = r_row;
                n_res.write_col   = r_col;
                n_res.write_char  = i_cmd.ch;
            end
            default: begin
                n_row = r_row;
                n_col = r_col;
            end
        endcase
        n_res.cursor_row = n_row;
        n_res.cursor_col = n_col;
    end

    // a tab stays at the queue head until its last space beat
    assign o_cmd_pop = fire && ((i_cmd.op != OP_TAB) || tab_done);

    always_comb begin
        n_tab_cnt = r_tab_cnt;
        if (fire && (i_cmd.op == OP_TAB)) begin
            n_tab_cnt = tab_done ? '0 : r_tab_cnt + 1'b1;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (fire) begin
            n_out_valid = 1'b1;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row       <= '0;
            r_col       <= '0;
            r_tab_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_row <= n_row;
                r_col <= n_col;
            end
            r_tab_cnt   <= n_tab_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= n_res;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.write_valid = r_out.write_valid;
    assign o_res.write_row   = r_out.write_row;
    assign o_res.write_col   = r_out.write_col;
    assign o_res.write_char  = r_out.write_char;
    assign o_res.cursor_row  = r_out.cursor_row;
    assign o_res.cursor_col  = r_out.cursor_col;
    assign o_res.last_result = r_out.last_result;

    `TCKE_ASSERT(a_row_in_window, r_row <= ROW_LAST)
    `TCKE_ASSERT(a_col_in_window, r_col <= COL_LAST)
    `TCKE_ASSERT(a_tab_cnt_on_tab, (r_tab_cnt != '0) |-> (i_cmd_valid && (i_cmd.op == OP_TAB)))
    `TCKE_ASSERT(a_move_is_last, (r_out_valid && !r_out.write_valid) |-> r_out.last_result)
    `TCKE_ASSERT(a_write_printable, (r_out_valid && r_out.write_valid) |-> (r_out.write_char >= CHAR_SPACE))
    `TCKE_ASSERT_ALWAYS(a_reset_clears, !$past(i_rst_n) |-> (!r_out_valid && (r_tab_cnt == '0)))

endmodule

[rtl/text_cursor_key_editor.sv]
// ----------------------------------------------------------------------------
// text_cursor_key_editor
// keyboard driven cursor for a 16 x 63 text window emitting cell writes
// ----------------------------------------------------------------------------
// i_key carries one key code per beat; o_res carries cell writes and cursor
// moves, last_result marking the final beat caused by a key. Dead keys
// (unlisted control codes, 128..255) are accepted and give no beat.
// A key is taken whenever the two-entry command queue has room; the front
// decoder never waits on the output side.
// A key is written into the command queue, and its results into the output
// register. Throughput: one result beat per cycle from the back executor while
// the receiver is ready; a tab gives TAB_N space beats (4 here).
// Reset clears the cursor to row 0, column 0 and empties the queue and the
// output register. When the receiver stalls the output register holds its
// beat, the executor stops, the queue fills and then i_key.ready drops.
// ----------------------------------------------------------------------------
module text_cursor_key_editor import tcke_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tcke_key_if.sink   i_key,
    tcke_res_if.source o_res
);

    logic queue_full;
    logic push;
    t_cmd push_cmd;
    logic pop;
    logic head_valid;
    t_cmd head_cmd;

    tcke_front u_front (
        .i_key        (i_key),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_push_cmd   (push_cmd)
    );

    tcke_cmd_fifo u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .o_full     (queue_full),
        .i_pop      (pop),
        .o_valid    (head_valid),
        .o_head     (head_cmd)
    );

    tcke_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (head_valid),
        .i_cmd       (head_cmd),
        .o_cmd_pop   (pop),
        .o_res       (o_res)
    );

endmodule

[dv/text_cursor_key_editor_tb.sv]
// ----------------------------------------------------------------------------
// text_cursor_key_editor_tb
// self-checking bench: key codes go in on the key channel, and every result
// beat is compared field by field with a cursor model kept in the bench.
// A short directed table covers edges, clamps, the last cell and dead keys.
// Random keys follow, with random gaps on both sides and a full drain midway.
// ----------------------------------------------------------------------------
module text_cursor_key_editor_tb;
    import tcke_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RAND_KEYS   = 445;
    localparam int TAIL_CYCLES = 8;

    typedef struct {
        logic [KEY_W-1:0] key;
        bit               typed;
        t_res             want;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    tcke_key_if key_if ();
    tcke_res_if res_if ();

    text_cursor_key_editor u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_key   (key_if),
        .o_res   (res_if)
    );

    // bench copy of the cursor and the beats still owed by the block
    logic [ROW_W-1:0] cur_row;
    logic [COL_W-1:0] cur_col;
    t_res             due_beats[$];
    t_dir_row         dir_tab[$];

    bit calm;
    int errors;
    int cycles;
    int keys_sent;
    int beats_seen;
    int cells_written;
    int tabs_sent;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats still due", cycles,
                     due_beats.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic t_res beat(bit wv, int wr, int wc, int ch, int cr, int cc);
        t_res b;
        b.write_valid = wv;
        b.write_row   = ROW_W'(wr);
        b.write_col   = COL_W'(wc);
        b.write_char  = CHAR_W'(ch);
        b.cursor_row  = ROW_W'(cr);
        b.cursor_col  = COL_W'(cc);
        b.last_result = 1'b1;
        return b;
    endfunction

    function automatic void advance_cursor();
        if (cur_col < COL_LAST) begin
            cur_col++;
        end else if (cur_row < ROW_LAST) begin
            cur_col = '0;
            cur_row++;
        end
    endfunction

    function automatic void push_beat(bit wv, logic [ROW_W-1:0] wr,
                                      logic [COL_W-1:0] wc, logic [CHAR_W-1:0] ch);
        t_res b;
        b.write_valid = wv;
        b.write_row   = wv ? wr : '0;
        b.write_col   = wv ? wc : '0;
        b.write_char  = wv ? ch : '0;
        b.cursor_row  = cur_row;
        b.cursor_col  = cur_col;
        b.last_result = 1'b0;
        due_beats.push_back(b);
    endfunction

    // updates the cursor for one key and queues its beats; returns the count
    function automatic int apply_key(logic [KEY_W-1:0] key);
        int               n;
        bit               moved;
        t_res             b;
        logic [ROW_W-1:0] wr;
        logic [COL_W-1:0] wc;
        n     = 0;
        moved = 1'b1;
        case (key)
            KEY_UP:     if (cur_row != '0) cur_row--;
            KEY_DOWN:   if (cur_row < ROW_LAST) cur_row++;
            KEY_LEFT:   if (cur_col != '0) cur_col--;
            KEY_RIGHT:  if (cur_col < COL_LAST) cur_col++;
            KEY_HOME:   cur_col = '0;
            KEY_END:    cur_col = COL_LAST;
            KEY_TOP:    cur_row = '0;
            KEY_BOTTOM: cur_row = ROW_LAST;
            KEY_ENTER: begin
                cur_col = '0;
                if (cur_row < ROW_LAST) cur_row++;
            end
            KEY_BKSP: begin
                moved = 1'b0;
                if (cur_col != '0) cur_col--;
                wr = cur_row;
                wc = cur_col;
                advance_cursor();
                if (cur_col != '0) cur_col--;
                push_beat(1'b1, wr, wc, CHAR_SPACE);
                n = 1;
            end
            KEY_TAB: begin
                moved = 1'b0;
                for (int i = 0; i < TAB_N; i++) begin
                    wr = cur_row;
                    wc = cur_col;
                    advance_cursor();
                    push_beat(1'b1, wr, wc, CHAR_SPACE);
                end
                n = TAB_N;
            end
            default: begin
                moved = 1'b0;
                if (key >= KEY_PRINT_LO && key <= KEY_PRINT_HI) begin
                    wr = cur_row;
                    wc = cur_col;
                    advance_cursor();
                    push_beat(1'b1, wr, wc, key[CHAR_W-1:0]);
                    n = 1;
                end
            end
        endcase
        if (moved) begin
            push_beat(1'b0, '0, '0, '0);
            n = 1;
        end
        if (n > 0) begin
            b = due_beats.pop_back();
            b.last_result = 1'b1;
            due_beats.push_back(b);
        end
        return n;
    endfunction

    function automatic void add_key(logic [KEY_W-1:0] key);
        t_dir_row r;
        r.key   = key;
        r.typed = 1'b0;
        r.want  = '0;
        dir_tab.push_back(r);
    endfunction

    function automatic void add_typed(logic [KEY_W-1:0] key, t_res want);
        t_dir_row r;
        r.key   = key;
        r.typed = 1'b1;
        r.want  = want;
        dir_tab.push_back(r);
    endfunction

    function automatic int pick_gap();
        return calm ? 0 : $urandom_range(0, 8);
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return KEY_W'($urandom_range(32, 127));
        if (r < 63) return KEY_TAB;
        if (r < 69) return KEY_BKSP;
        if (r < 92) begin
            case ($urandom_range(0, 8))
                0: return KEY_UP;
                1: return KEY_DOWN;
                2: return KEY_LEFT;
                3: return KEY_RIGHT;
                4: return KEY_HOME;
                5: return KEY_END;
                6: return KEY_TOP;
                7: return KEY_BOTTOM;
                default: return KEY_ENTER;
            endcase
        end
        // noise: any code, high half and dead control codes included
        return KEY_W'($urandom_range(0, 255));
    endfunction

    // one beat on the key channel; valid stays high when there is no gap
    task automatic send_key(input logic [KEY_W-1:0] key, input int gap,
                            input bit drain);
        if (gap > 0) begin
            key_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        while (drain && due_beats.size() != 0) @(posedge i_clk);
        key_if.valid    <= 1'b1;
        key_if.key_code <= key;
        do @(posedge i_clk); while (!key_if.ready);
        keys_sent++;
        if (key == KEY_TAB) tabs_sent++;
    endtask

    // result side: random stalls, each accepted beat checked against the oldest due
    initial begin
        t_res got;
        t_res want;
        int   stall;
        res_if.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = pick_gap();
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_if.valid && res_if.ready));
            got.write_valid = res_if.write_valid;
            got.write_row   = res_if.write_row;
            got.write_col   = res_if.write_col;
            got.write_char  = res_if.write_char;
            got.cursor_row  = res_if.cursor_row;
            got.cursor_col  = res_if.cursor_col;
            got.last_result = res_if.last_result;
            beats_seen++;
            if (got.write_valid === 1'b1) cells_written++;
            if (due_beats.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat wv=%0d wr=%0d wc=%0d ch=%0d cur=%0d,%0d last=%0d",
                         $time, got.write_valid, got.write_row, got.write_col,
                         got.write_char, got.cursor_row, got.cursor_col, got.last_result);
            end else begin
                want = due_beats.pop_front();
                if (got !== want) begin
                    errors++;
                    $display("%0t: mismatch expected wv=%0d wr=%0d wc=%0d ch=%0d cur=%0d,%0d last=%0d",
                             $time, want.write_valid, want.write_row, want.write_col,
                             want.write_char, want.cursor_row, want.cursor_col,
                             want.last_result);
                    $display("%0t:          actual   wv=%0d wr=%0d wc=%0d ch=%0d cur=%0d,%0d last=%0d",
                             $time, got.write_valid, got.write_row, got.write_col,
                             got.write_char, got.cursor_row, got.cursor_col,
                             got.last_result);
                end
            end
        end
    end

    // key side
    initial begin
        int               n;
        int               made;
        logic [KEY_W-1:0] key;
        errors          = 0;
        cycles          = 0;
        keys_sent       = 0;
        beats_seen      = 0;
        cells_written   = 0;
        tabs_sent       = 0;
        calm            = 1'b0;
        cur_row         = '0;
        cur_col         = '0;
        i_rst_n         <= 1'b0;
        key_if.valid    <= 1'b0;
        key_if.key_code <= '0;

        add_typed(KEY_UP,     beat(0, 0, 0, 0, 0, 0));
        add_typed(KEY_LEFT,   beat(0, 0, 0, 0, 0, 0));
        add_key(8'd255);
        add_key(8'd128);
        add_key(8'd7);
        add_key(8'd8);
        add_key(8'd24);
        add_key(8'd0);
        add_key(8'd31);
        add_typed(KEY_END,    beat(0, 0, 0, 0, 0, 62));
        add_typed(KEY_RIGHT,  beat(0, 0, 0, 0, 0, 62));
        add_typed(8'd127,     beat(1, 0, 62, 127, 1, 0));
        add_typed(KEY_BOTTOM, beat(0, 0, 0, 0, 15, 0));
        add_typed(KEY_DOWN,   beat(0, 0, 0, 0, 15, 0));
        add_typed(KEY_END,    beat(0, 0, 0, 0, 15, 62));
        // write at the last cell leaves the cursor there
        add_typed(8'd32,      beat(1, 15, 62, 32, 15, 62));
        add_key(KEY_TAB);
        add_typed(KEY_ENTER,  beat(0, 0, 0, 0, 15, 0));
        add_key(KEY_BKSP);
        add_key(KEY_TOP);
        add_key(KEY_TAB);
        add_key(KEY_BKSP);
        add_key(KEY_HOME);
        add_key(8'd65);
        add_key(KEY_ENTER);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[i]) begin
            send_key(dir_tab[i].key, pick_gap(), 1'b0);
            n = apply_key(dir_tab[i].key);
            if (dir_tab[i].typed) begin
                void'(due_beats.pop_back());
                due_beats.push_back(dir_tab[i].want);
            end
        end

        made = 0;
        while (made < RAND_KEYS) begin
            // every third stretch of 60 keys runs back to back on both sides
            calm = ((made / 60) % 3) == 2;
            key  = pick_key();
            if (made == 200) begin
                send_key(key, 1 + $urandom_range(0, 7), 1'b1);
            end else begin
                send_key(key, pick_gap(), 1'b0);
            end
            n = apply_key(key);
            if (n > 0) made++;
        end
        key_if.valid <= 1'b0;
        calm = 1'b0;

        while (due_beats.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("sent %0d keys (%0d tabs); checked %0d result beats, %0d cell writes",
                 keys_sent, tabs_sent, beats_seen, cells_written);
        $display("final cursor row %0d col %0d, %0d mismatches", cur_row, cur_col, errors);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
